### rtl/ethcls_pkg.sv
// ----------------------------------------------------------------------------
// ethcls_pkg
// Shared types and constants for the frame classifier: verdict codes,
// header offsets and the record handed from the parser to the top level.
// ----------------------------------------------------------------------------
package ethcls_pkg;

  typedef enum logic [1:0] {
    VERDICT_DROP_OTHER = 2'd0,
    VERDICT_FWD_UDP    = 2'd1,
    VERDICT_DROP_TCP   = 2'd2,
    VERDICT_DROP_LINK  = 2'd3
  } verdict_e;

  localparam logic [15:0] ETHERTYPE_VLAN = 16'h8100;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [15:0] MIN_LEN_TCP    = 16'd40;
  localparam logic [15:0] MIN_LEN_UDP    = 16'd28;

  // Byte index of the first ethertype byte with no tags, and tag size.
  localparam logic [15:0] ETYPE_POS      = 16'd12;
  localparam logic [15:0] VLAN_TAG_BYTES = 16'd4;

  // Offsets inside the fixed IPv4 header, counted from its first byte.
  localparam logic [15:0] IP_OFF_LEN_HI  = 16'd2;
  localparam logic [15:0] IP_OFF_LEN_LO  = 16'd3;
  localparam logic [15:0] IP_OFF_PROTO   = 16'd9;
  localparam logic [15:0] IP_OFF_SRC     = 16'd12;
  localparam logic [15:0] IP_OFF_DST     = 16'd16;
  localparam logic [15:0] IP_OFF_PORTS   = 16'd20;
  localparam logic [15:0] IP_OFF_END     = 16'd24;
  // Last destination port byte sits this far past the first ethertype byte.
  localparam logic [15:0] L4_LAST_POS    = 16'd25;

  localparam logic [15:0] POS_MAX        = 16'hFFFF;

  typedef struct packed {
    verdict_e    verdict;
    logic [7:0]  ip_protocol;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [2:0]  tag_count;
  } frame_res_t;

  typedef struct packed {
    logic [31:0] frames_seen;
    logic [31:0] frames_forwarded;
    logic [31:0] frames_dropped;
  } stats_t;

endpackage

### rtl/udp_tcp_frame_classifier_core.sv
// ----------------------------------------------------------------------------
// udp_tcp_frame_classifier_core
// Ethernet/VLAN/IPv4 header classifier: takes a frame one byte per request
// and returns one verdict request with the captured header fields and the
// frame counters on the final byte of each frame.
// ----------------------------------------------------------------------------
//
//  channel | handshake               | payload
//  --------+-------------------------+----------------------------------------
//  in      | in_valid_i / in_ready_o | frame_byte_i, last_byte_i,
//          |                         | tx_link_up_i, clear_counters_i
//  out     | out_valid_o/out_ready_i | verdict_o, ip_protocol_o, addresses,
//          |                         | ports, tag_count_o, frames_*_o
//
// One byte per cycle, unless a final byte waits for a full result register.
// A byte is held in the input register, then processed into the result
// register. Only final bytes need the result register; other bytes advance
// even while a result waits. Reset clears all frame state and counters. A
// stalled output holds only the final byte of the next frame.
// ----------------------------------------------------------------------------
module udp_tcp_frame_classifier_core import ethcls_pkg::*; #(
  parameter int MAX_VLAN_TAGS = 4,
  parameter int COUNTER_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  frame_byte_i,
  input  logic        last_byte_i,
  input  logic        tx_link_up_i,
  input  logic        clear_counters_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  verdict_o,
  output logic [7:0]  ip_protocol_o,
  output logic [31:0] source_address_o,
  output logic [31:0] dest_address_o,
  output logic [15:0] source_port_o,
  output logic [15:0] dest_port_o,
  output logic [2:0]  tag_count_o,
  output logic [31:0] frames_seen_o,
  output logic [31:0] frames_forwarded_o,
  output logic [31:0] frames_dropped_o
);

  // Input register
  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       link_q;
  logic       clr_q;

  // Result register
  logic       out_valid_q;
  frame_res_t res_q;
  stats_t     stats_q;

  frame_res_t res;
  stats_t     stats;
  logic       out_free;
  logic       step;
  logic       in_accept;

  // A held byte advances unless it is a final byte and the result slot is
  // still occupied.
  assign out_free   = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && (!last_q || out_free);
  assign in_ready_o = !in_valid_q || step;
  assign in_accept  = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Payload needs no reset; load on accept.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byte_q <= frame_byte_i;
      last_q <= last_byte_i;
      link_q <= tx_link_up_i;
      clr_q  <= clear_counters_i;
    end
  end

  ethcls_parser #(
    .MAX_VLAN_TAGS(MAX_VLAN_TAGS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .frame_byte_i(byte_q),
    .last_byte_i (last_q),
    .tx_link_up_i(link_q),
    .res_o       (res)
  );

  ethcls_stats #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_stats (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .clear_i    (clr_q),
    .last_byte_i(last_q),
    .verdict_i  (res.verdict),
    .stats_o    (stats)
  );

  // Result valid: set by a stepped final byte, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && last_q) begin
      res_q   <= res;
      stats_q <= stats;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign verdict_o          = res_q.verdict;
  assign ip_protocol_o      = res_q.ip_protocol;
  assign source_address_o   = res_q.source_address;
  assign dest_address_o     = res_q.dest_address;
  assign source_port_o      = res_q.source_port;
  assign dest_port_o        = res_q.dest_port;
  assign tag_count_o        = res_q.tag_count;
  assign frames_seen_o      = stats_q.frames_seen;
  assign frames_forwarded_o = stats_q.frames_forwarded;
  assign frames_dropped_o   = stats_q.frames_dropped;

endmodule

### rtl/ethcls_parser.sv
// ----------------------------------------------------------------------------
// ethcls_parser
// Per-frame header state: byte position, VLAN tag skipping, ethertype and
// IPv4/L4 field capture. Gives the frame result for the byte being stepped.
// ----------------------------------------------------------------------------
module ethcls_parser import ethcls_pkg::*; #(
  parameter int MAX_VLAN_TAGS = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] frame_byte_i,
  input  logic       last_byte_i,
  input  logic       tx_link_up_i,
  output frame_res_t res_o
);

  localparam int HW = $clog2(MAX_VLAN_TAGS + 1);
  localparam logic [HW-1:0] TAG_LIMIT = HW'(MAX_VLAN_TAGS);

  logic [15:0]   pos_q, pos_d;
  logic [HW-1:0] tags_q, tags_d;
  logic [15:0]   etype_q, etype_d;
  logic [15:0]   tot_len_q, tot_len_d;
  logic [7:0]    proto_q, proto_d;
  logic [31:0]   src_q, src_d;
  logic [31:0]   dst_q, dst_d;
  logic [31:0]   ports_q, ports_d;
  logic          bad_q, bad_d;

  logic [15:0] etype_pos, etype_pos_new, ip_off;
  logic [1:0]  lane;
  logic        frame_ok;

  always_comb begin
    pos_d     = pos_q;
    tags_d    = tags_q;
    etype_d   = etype_q;
    tot_len_d = tot_len_q;
    proto_d   = proto_q;
    src_d     = src_q;
    dst_d     = dst_q;
    ports_d   = ports_q;
    bad_d     = bad_q;

    etype_pos = ETYPE_POS + 16'(tags_q) * VLAN_TAG_BYTES;
    ip_off    = pos_q - (etype_pos + 16'd2);
    lane      = ip_off[1:0];

    if (!bad_q) begin
      if (pos_q <= etype_pos + 16'd1) begin
        etype_d = {etype_q[7:0], frame_byte_i};
        if (pos_q == etype_pos + 16'd1 && etype_d == ETHERTYPE_VLAN) begin
          if (tags_q >= TAG_LIMIT) begin
            bad_d = 1'b1;
          end else begin
            tags_d = tags_q + HW'(1);
          end
        end
      end else if (etype_q == ETHERTYPE_IPV4 && ip_off < IP_OFF_END) begin
        if (ip_off == IP_OFF_LEN_HI) begin
          tot_len_d[15:8] = frame_byte_i;
        end else if (ip_off == IP_OFF_LEN_LO) begin
          tot_len_d[7:0] = frame_byte_i;
        end else if (ip_off == IP_OFF_PROTO) begin
          proto_d = frame_byte_i;
        end else if (ip_off >= IP_OFF_SRC && ip_off < IP_OFF_DST) begin
          src_d[8*(2'd3 - lane) +: 8] = frame_byte_i;
        end else if (ip_off >= IP_OFF_DST && ip_off < IP_OFF_PORTS) begin
          dst_d[8*(2'd3 - lane) +: 8] = frame_byte_i;
        end else if (ip_off >= IP_OFF_PORTS) begin
          ports_d[8*(2'd3 - lane) +: 8] = frame_byte_i;
        end
      end
    end

    if (pos_q < POS_MAX) begin
      pos_d = pos_q + 16'd1;
    end

    // Verdict uses the state after this byte; pos_q is this byte's index.
    etype_pos_new = ETYPE_POS + 16'(tags_d) * VLAN_TAG_BYTES;
    frame_ok = !bad_d && etype_d == ETHERTYPE_IPV4 &&
               pos_q >= etype_pos_new + L4_LAST_POS;

    res_o.verdict = VERDICT_DROP_OTHER;
    if (frame_ok) begin
      if (proto_d == PROTO_TCP && tot_len_d >= MIN_LEN_TCP) begin
        res_o.verdict = VERDICT_DROP_TCP;
      end else if (proto_d == PROTO_UDP && tot_len_d >= MIN_LEN_UDP) begin
        res_o.verdict = tx_link_up_i ? VERDICT_FWD_UDP : VERDICT_DROP_LINK;
      end
    end
    res_o.ip_protocol    = proto_d;
    res_o.source_address = src_d;
    res_o.dest_address   = dst_d;
    res_o.source_port    = ports_d[31:16];
    res_o.dest_port      = ports_d[15:0];
    res_o.tag_count      = 3'(tags_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      tags_q    <= '0;
      etype_q   <= '0;
      tot_len_q <= '0;
      proto_q   <= '0;
      src_q     <= '0;
      dst_q     <= '0;
      ports_q   <= '0;
      bad_q     <= 1'b0;
    end else if (step_i) begin
      if (last_byte_i) begin
        // Clear all frame state after the final byte.
        pos_q     <= '0;
        tags_q    <= '0;
        etype_q   <= '0;
        tot_len_q <= '0;
        proto_q   <= '0;
        src_q     <= '0;
        dst_q     <= '0;
        ports_q   <= '0;
        bad_q     <= 1'b0;
      end else begin
        pos_q     <= pos_d;
        tags_q    <= tags_d;
        etype_q   <= etype_d;
        tot_len_q <= tot_len_d;
        proto_q   <= proto_d;
        src_q     <= src_d;
        dst_q     <= dst_d;
        ports_q   <= ports_d;
        bad_q     <= bad_d;
      end
    end
  end

endmodule

### rtl/ethcls_stats.sv
// ----------------------------------------------------------------------------
// ethcls_stats
// Wrapping frame, forward and drop counters with synchronous clear.
// Reports the low 32 bits of the counters after the current byte.
// ----------------------------------------------------------------------------
module ethcls_stats import ethcls_pkg::*; #(
  parameter int COUNTER_WIDTH = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  logic     clear_i,
  input  logic     last_byte_i,
  input  verdict_e verdict_i,
  output stats_t   stats_o
);

  logic [COUNTER_WIDTH-1:0] seen_q, seen_d;
  logic [COUNTER_WIDTH-1:0] fwd_q, fwd_d;
  logic [COUNTER_WIDTH-1:0] drop_q, drop_d;

  always_comb begin
    seen_d = clear_i ? '0 : seen_q;
    fwd_d  = clear_i ? '0 : fwd_q;
    drop_d = clear_i ? '0 : drop_q;
    if (last_byte_i) begin
      seen_d = seen_d + COUNTER_WIDTH'(1);
      unique case (verdict_i) inside
        VERDICT_FWD_UDP:                     fwd_d  = fwd_d + COUNTER_WIDTH'(1);
        VERDICT_DROP_TCP, VERDICT_DROP_LINK: drop_d = drop_d + COUNTER_WIDTH'(1);
        default: ;
      endcase
    end
    stats_o.frames_seen      = 32'(seen_d);
    stats_o.frames_forwarded = 32'(fwd_d);
    stats_o.frames_dropped   = 32'(drop_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      fwd_q  <= '0;
      drop_q <= '0;
    end else if (step_i) begin
      seen_q <= seen_d;
      fwd_q  <= fwd_d;
      drop_q <= drop_d;
    end
  end

endmodule

### verif/udp_tcp_frame_classifier_core_test.sv
// ----------------------------------------------------------------------------
// udp_tcp_frame_classifier_core_test
// Self-checking bench for the frame classifier. It streams Ethernet frames
// one byte per request (directed corner frames first, then random frames,
// most of them well-formed headers with random content). A model of the
// header parser inside the bench predicts one verdict request per frame,
// and each verdict request is checked field by field against it. Both sides
// idle at random in the first two phases and run at full rate in the third.
// ----------------------------------------------------------------------------
module udp_tcp_frame_classifier_core_test import ethcls_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_TAGS    = 4;
  localparam int STALL_LIMIT = 2000;

  // One byte request as the driver presents it.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       link_up;
    logic       clear;
    logic       hold_for_drain;  // wait for every verdict before sending this byte
  } wire_byte_t;

  // Everything one verdict request carries.
  typedef struct packed {
    frame_res_t hdr;
    stats_t     stats;
  } frame_rec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic       in_valid = 1'b0;
  wire_byte_t cur_byte = '0;
  logic       out_ready = 1'b0;

  logic        in_ready;
  logic        out_valid;
  logic [1:0]  verdict;
  logic [7:0]  ip_protocol;
  logic [31:0] source_address;
  logic [31:0] dest_address;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic [2:0]  tag_count;
  logic [31:0] frames_seen;
  logic [31:0] frames_forwarded;
  logic [31:0] frames_dropped;

  // Bytes still to send, and verdicts predicted but not yet received.
  wire_byte_t wire_bytes[$];
  frame_rec_t expected_verdicts[$];

  int bytes_queued = 0;
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_cycles = 0;
  bit send_gap;
  bit byte_taken = 1'b0;
  bit verdict_taken = 1'b0;
  frame_rec_t want;

  // Parser state mirrored by the bench.
  logic [15:0] pos_cnt = '0;
  logic [4:0]  tag_cnt = '0;
  logic [15:0] type_sr = '0;
  logic [15:0] ip_total_len = '0;
  logic [7:0]  ip_proto = '0;
  logic [31:0] ip_src = '0;
  logic [31:0] ip_dst = '0;
  logic [31:0] l4_ports = '0;
  logic        too_many_tags = 1'b0;
  logic [31:0] seen_cnt = '0;
  logic [31:0] fwd_cnt = '0;
  logic [31:0] drop_cnt = '0;

  always #5 clk = ~clk;

  udp_tcp_frame_classifier_core #(
    .MAX_VLAN_TAGS(MAX_TAGS),
    .COUNTER_WIDTH(32)
  ) u_top (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .frame_byte_i       (cur_byte.data),
    .last_byte_i        (cur_byte.last),
    .tx_link_up_i       (cur_byte.link_up),
    .clear_counters_i   (cur_byte.clear),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .verdict_o          (verdict),
    .ip_protocol_o      (ip_protocol),
    .source_address_o   (source_address),
    .dest_address_o     (dest_address),
    .source_port_o      (source_port),
    .dest_port_o        (dest_port),
    .tag_count_o        (tag_count),
    .frames_seen_o      (frames_seen),
    .frames_forwarded_o (frames_forwarded),
    .frames_dropped_o   (frames_dropped)
  );

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, exp_val));
  endtask

  // Advance the parser model by one accepted byte; on the final byte of a
  // frame, classify it and push the verdict it must produce.
  task automatic classify_byte(wire_byte_t b);
    int p;
    int e;
    int off;
    verdict_e v;
    frame_rec_t rec;
    p = pos_cnt;
    e = ETYPE_POS + VLAN_TAG_BYTES * tag_cnt;

    // Clear acts before the byte itself is counted.
    if (b.clear) begin
      seen_cnt = '0;
      fwd_cnt  = '0;
      drop_cnt = '0;
    end

    if (!too_many_tags) begin
      if (p <= e + 1) begin
        // Still in front of the ethertype: shift the last two bytes in.
        type_sr = {type_sr[7:0], b.data};
        if (p == e + 1 && type_sr == ETHERTYPE_VLAN) begin
          if (tag_cnt >= MAX_TAGS) too_many_tags = 1'b1;
          else tag_cnt = tag_cnt + 1'b1;
        end
      end else if (type_sr == ETHERTYPE_IPV4) begin
        // Fixed 20-byte IPv4 header, then the two L4 ports; IHL is ignored.
        off = p - (e + 2);
        if (off == IP_OFF_LEN_HI) ip_total_len[15:8] = b.data;
        else if (off == IP_OFF_LEN_LO) ip_total_len[7:0] = b.data;
        else if (off == IP_OFF_PROTO) ip_proto = b.data;
        else if (off >= IP_OFF_SRC && off < IP_OFF_DST)
          ip_src[8 * (IP_OFF_DST - 1 - off) +: 8] = b.data;
        else if (off >= IP_OFF_DST && off < IP_OFF_PORTS)
          ip_dst[8 * (IP_OFF_PORTS - 1 - off) +: 8] = b.data;
        else if (off >= IP_OFF_PORTS && off < IP_OFF_END)
          l4_ports[8 * (IP_OFF_END - 1 - off) +: 8] = b.data;
      end
    end

    if (pos_cnt != POS_MAX) pos_cnt = pos_cnt + 1'b1;

    if (b.last) begin
      e = ETYPE_POS + VLAN_TAG_BYTES * tag_cnt;
      v = VERDICT_DROP_OTHER;
      // Only a frame that reached its last port byte can be classified.
      if (!too_many_tags && type_sr == ETHERTYPE_IPV4 && p >= e + L4_LAST_POS) begin
        if (ip_proto == PROTO_TCP && ip_total_len >= MIN_LEN_TCP)
          v = VERDICT_DROP_TCP;
        else if (ip_proto == PROTO_UDP && ip_total_len >= MIN_LEN_UDP)
          v = b.link_up ? VERDICT_FWD_UDP : VERDICT_DROP_LINK;
      end

      seen_cnt = seen_cnt + 1'b1;
      if (v == VERDICT_FWD_UDP) fwd_cnt = fwd_cnt + 1'b1;
      else if (v == VERDICT_DROP_TCP || v == VERDICT_DROP_LINK) drop_cnt = drop_cnt + 1'b1;

      rec.hdr.verdict          = v;
      rec.hdr.ip_protocol      = ip_proto;
      rec.hdr.source_address   = ip_src;
      rec.hdr.dest_address     = ip_dst;
      rec.hdr.source_port      = l4_ports[31:16];
      rec.hdr.dest_port        = l4_ports[15:0];
      rec.hdr.tag_count        = tag_cnt[2:0];
      rec.stats.frames_seen      = seen_cnt;
      rec.stats.frames_forwarded = fwd_cnt;
      rec.stats.frames_dropped   = drop_cnt;
      expected_verdicts.push_back(rec);

      // Drop all per-frame state for the next frame.
      pos_cnt       = '0;
      tag_cnt       = '0;
      type_sr       = '0;
      ip_total_len  = '0;
      ip_proto      = '0;
      ip_src        = '0;
      ip_dst        = '0;
      l4_ports      = '0;
      too_many_tags = 1'b0;
    end
  endtask

  function automatic logic [7:0] body_byte(int fill);
    return (fill < 0) ? 8'($urandom) : 8'(fill);
  endfunction

  // Build one frame: MACs, ntags VLAN tags, ethertype, IPv4 header, ports,
  // then padding. trim shortens (negative) or pads (positive) the frame
  // relative to the full header; fill < 0 means random body bytes.
  task automatic queue_frame(int ntags, logic [15:0] etype, logic [7:0] proto,
                             logic [15:0] ip_len, int trim, int fill,
                             bit link, bit drain, bit clr_last);
    logic [7:0] raw[$];
    wire_byte_t item;
    int length;
    for (int i = 0; i < 12; i++) raw.push_back(body_byte(fill));
    repeat (ntags) begin
      raw.push_back(ETHERTYPE_VLAN[15:8]);
      raw.push_back(ETHERTYPE_VLAN[7:0]);
      raw.push_back(body_byte(fill));
      raw.push_back(body_byte(fill));
    end
    raw.push_back(etype[15:8]);
    raw.push_back(etype[7:0]);
    for (int i = 0; i < IP_OFF_END; i++) begin
      if (i == IP_OFF_LEN_HI) raw.push_back(ip_len[15:8]);
      else if (i == IP_OFF_LEN_LO) raw.push_back(ip_len[7:0]);
      else if (i == IP_OFF_PROTO) raw.push_back(proto);
      else raw.push_back(body_byte(fill));
    end
    length = raw.size() + trim;
    if (length < 1) length = 1;
    while (raw.size() < length) raw.push_back(body_byte(fill));

    for (int i = 0; i < length; i++) begin
      item.data           = raw[i];
      item.last           = (i == length - 1);
      // Link status only matters on the final byte; toggle it elsewhere.
      item.link_up        = item.last ? link : 1'($urandom_range(1));
      item.clear          = ($urandom_range(149) == 0) || (clr_last && item.last);
      item.hold_for_drain = drain && (i == 0);
      wire_bytes.push_back(item);
    end
    bytes_queued += length;
  endtask

  // Mostly well-formed headers with random content; some noise, broken tag
  // stacks, foreign ethertypes and truncated frames.
  task automatic queue_random_frame();
    int kind;
    int ntags;
    int trim;
    int fill;
    logic [15:0] etype;
    logic [7:0]  proto;
    logic [15:0] ip_len;
    kind = $urandom_range(99);
    if (kind < 8) begin
      queue_frame(0, 16'($urandom), 8'($urandom), 16'($urandom),
                  int'($urandom_range(40, 1)) - 38, -1, 1'($urandom_range(1)), 1'b0, 1'b0);
    end else begin
      ntags = ($urandom_range(9) == 0) ? $urandom_range(MAX_TAGS + 2, MAX_TAGS + 1)
                                       : $urandom_range(MAX_TAGS, 0);
      etype = ($urandom_range(99) < 88) ? ETHERTYPE_IPV4 : 16'($urandom);
      kind  = $urandom_range(99);
      proto = (kind < 40) ? PROTO_UDP : (kind < 80) ? PROTO_TCP : 8'($urandom);
      // Half of the lengths sit right around the minimum for the protocol.
      if ($urandom_range(1) == 0)
        ip_len = 16'(((proto == PROTO_TCP) ? MIN_LEN_TCP : MIN_LEN_UDP) +
                     $urandom_range(4) - 2);
      else
        ip_len = 16'($urandom);
      if ($urandom_range(99) < 75) trim = $urandom_range(8);
      else trim = -int'($urandom_range(37 + 4 * ntags, 1));
      kind = $urandom_range(99);
      fill = (kind < 90) ? -1 : (kind < 95) ? 8'h00 : 8'hFF;
      queue_frame(ntags, etype, proto, ip_len, trim, fill,
                  $urandom_range(99) < 75, $urandom_range(19) == 0, 1'b0);
    end
  endtask

  task automatic wait_drained();
    while (wire_bytes.size() != 0 || in_valid || expected_verdicts.size() != 0)
      @(posedge clk);
  endtask

  // Driver: update inputs on the falling edge so they are stable at the
  // rising edge where the block samples them.
  always @(negedge clk) begin
    if (rst_n) begin
      send_gap = ($urandom_range(99) < send_idle_pct);

      if (in_valid && !byte_taken) begin
        // Hold the request until it is accepted.
      end else if (wire_bytes.size() != 0 && !send_gap &&
                   !(wire_bytes[0].hold_for_drain && expected_verdicts.size() != 0)) begin
        in_valid <= 1'b1;
        cur_byte <= wire_bytes.pop_front();
      end else begin
        in_valid <= 1'b0;
      end

      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: sample both handshakes on the rising edge. Check the outgoing
  // verdict before predicting from the incoming byte, so a byte accepted in
  // the same cycle never pairs with the verdict leaving now.
  always @(posedge clk) begin
    if (rst_n) begin
      verdict_taken = out_valid && out_ready;
      byte_taken    = in_valid && in_ready;

      if (verdict_taken) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch($sformatf("verdict request %0d with nothing pending", verdict));
        end else begin
          want = expected_verdicts.pop_front();
          compare_field("verdict", verdict, want.hdr.verdict);
          compare_field("ip_protocol", ip_protocol, want.hdr.ip_protocol);
          compare_field("source_address", source_address, want.hdr.source_address);
          compare_field("dest_address", dest_address, want.hdr.dest_address);
          compare_field("source_port", source_port, want.hdr.source_port);
          compare_field("dest_port", dest_port, want.hdr.dest_port);
          compare_field("tag_count", tag_count, want.hdr.tag_count);
          compare_field("frames_seen", frames_seen, want.stats.frames_seen);
          compare_field("frames_forwarded", frames_forwarded, want.stats.frames_forwarded);
          compare_field("frames_dropped", frames_dropped, want.stats.frames_dropped);
        end
      end

      if (byte_taken) classify_byte(cur_byte);

      // Watchdog: abort once nothing has moved for too long.
      if (byte_taken || verdict_taken) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Phase one: slow sender, slower receiver.
    send_idle_pct = 33;
    recv_idle_pct = 75;

    // Directed corner frames.
    queue_frame(0, ETHERTYPE_IPV4, PROTO_UDP, MIN_LEN_UDP, 0, -1, 1'b1, 1'b0, 1'b0);
    queue_frame(0, ETHERTYPE_IPV4, PROTO_UDP, MIN_LEN_UDP, 3, -1, 1'b0, 1'b0, 1'b0);
    queue_frame(1, ETHERTYPE_IPV4, PROTO_TCP, MIN_LEN_TCP, 0, -1, 1'b1, 1'b1, 1'b0);
    queue_frame(0, ETHERTYPE_IPV4, PROTO_TCP, MIN_LEN_TCP - 16'd1, 2, -1, 1'b1, 1'b0, 1'b0);
    queue_frame(2, ETHERTYPE_IPV4, PROTO_UDP, MIN_LEN_UDP - 16'd1, 0, -1, 1'b1, 1'b0, 1'b0);
    queue_frame(0, ETHERTYPE_IPV4, 8'd1, 16'hFFFF, 0, -1, 1'b1, 1'b0, 1'b0);
    // Deepest legal tag stack with addresses, ports and length at all ones.
    queue_frame(MAX_TAGS, ETHERTYPE_IPV4, PROTO_UDP, 16'hFFFF, 0, 8'hFF, 1'b1, 1'b0, 1'b0);
    // One tag too many: the frame goes bad.
    queue_frame(MAX_TAGS + 1, ETHERTYPE_IPV4, PROTO_UDP, MIN_LEN_UDP, 0, -1, 1'b1, 1'b0, 1'b0);
    queue_frame(0, 16'h86DD, PROTO_UDP, MIN_LEN_UDP, 0, -1, 1'b1, 1'b0, 1'b0);
    // Ends one byte before the last destination port byte.
    queue_frame(3, ETHERTYPE_IPV4, PROTO_UDP, MIN_LEN_UDP, -1, -1, 1'b1, 1'b0, 1'b0);
    // Single-byte frame.
    queue_frame(0, ETHERTYPE_IPV4, PROTO_UDP, MIN_LEN_UDP, -37, -1, 1'b1, 1'b0, 1'b0);
    // Ends inside the source address: partial lanes stay in place.
    queue_frame(0, ETHERTYPE_IPV4, PROTO_TCP, MIN_LEN_TCP, -10, -1, 1'b1, 1'b0, 1'b0);
    // All-zero content, counters cleared on the final byte.
    queue_frame(0, ETHERTYPE_IPV4, 8'h00, 16'h0000, 0, 8'h00, 1'b1, 1'b0, 1'b1);
    queue_frame(1, ETHERTYPE_IPV4, PROTO_UDP, MIN_LEN_UDP, 0, -1, 1'b1, 1'b1, 1'b0);

    while (bytes_queued < 1050) queue_random_frame();
    wait_drained();

    // Phase two: roles swapped.
    send_idle_pct = 75;
    recv_idle_pct = 33;
    while (bytes_queued < 1500) queue_random_frame();
    wait_drained();

    // Phase three: full rate on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (bytes_queued < 1950) queue_random_frame();
    wait_drained();

    // Let the two-stage pipe settle to catch any stray verdict.
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
